@@ hw/rtl/i2cmbe_pkg.sv @@
// Shared types and constants for the I2C master byte engine.
// No dependencies; imported by i2c_master_byte_engine_unit.
package i2cmbe_pkg;

    // Command codes carried in the kind field
    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_START    = 3'd1;
    localparam logic [2:0] KIND_STOP     = 3'd2;
    localparam logic [2:0] KIND_WRITE    = 3'd3;
    localparam logic [2:0] KIND_READ_ACK = 3'd4;
    localparam logic [2:0] KIND_READ_NAK = 3'd5;

    // Phase timing
    localparam logic [7:0] DELAY_RESET = 8'd32;
    localparam logic [7:0] DELAY_MIN   = 8'd1;

    // Bit counter: bit 3 marks a full byte on write, holds ACK level on read
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam int         ACK_BIT       = 3;

    // Bus phases
    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_ST_A  = 4'd1,
        PH_ST_B  = 4'd2,
        PH_SP_A  = 4'd3,
        PH_SP_B  = 4'd4,
        PH_SP_C  = 4'd5,
        PH_WR_LO = 4'd6,
        PH_WR_HI = 4'd7,
        PH_WA_LO = 4'd8,
        PH_WA_HI = 4'd9,
        PH_RD_LO = 4'd10,
        PH_RD_HI = 4'd11,
        PH_RA_LO = 4'd12,
        PH_RA_HI = 4'd13,
        PH_HOLD  = 4'd14
    } phase_t;

    // One result word as held in the output stage
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       nack;
        logic       bus_idle;
    } result_t;

endpackage

@@ hw/rtl/i2c_master_byte_engine_unit.sv @@
// I2C master byte engine: phase sequencer, bit shifter and output skid stage.
// Depends on i2cmbe_pkg for command codes, phase enum and result struct.

// Each accepted input word is one tick of the bus engine and yields exactly one
// result word. The tick is evaluated combinationally from the engine state
// registers and the input word; the result lands in an output register backed
// by a one-word skid register, so a new word is accepted every cycle as long
// as the skid register is empty. A command (start, stop, byte write, byte read
// with ACK or NACK) is taken only on a tick where the engine is idle and is
// ignored otherwise; every bus phase lasts delay_ticks ticks (0 acts as 1).
// Write delay_ticks only while idle.
module i2c_master_byte_engine_unit (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] kind,
    input  logic [7:0] tx_byte,
    input  logic       sda_in,
    input  logic       scl_in,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_out,
    output logic       sda_out,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] rx_byte,
    output logic       nack,
    output logic       bus_idle
);
    import i2cmbe_pkg::*;

    // Engine state
    logic [7:0] delay_reg;
    phase_t     phase_reg,  phase_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_reg,  shift_next;
    logic [7:0] tick_reg,   tick_next;
    logic [7:0] rx_reg,     rx_next;
    logic       nack_reg,   nack_next;
    logic       scl_reg,    scl_next;
    logic       sda_reg,    sda_next;
    logic       done_next;

    // Output stage
    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg,  skid_data_reg;
    result_t result_next;

    logic       accept;
    logic       out_take;
    logic [7:0] delay_eff;
    logic [8:0] tick_inc;
    logic [3:0] bit_inc;
    logic [7:0] shift_wr;
    logic [7:0] shift_rd;
    logic       ack_level;

    assign accept    = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;
    assign delay_eff = (delay_reg == 8'd0) ? DELAY_MIN : delay_reg;
    assign tick_inc  = {1'b0, tick_reg} + 9'd1;
    assign bit_inc   = bit_count_reg + 4'd1;
    assign shift_wr  = {shift_reg[6:0], 1'b0};
    assign shift_rd  = {shift_reg[6:0], sda_in};
    assign ack_level = bit_count_reg[ACK_BIT];

    // Next engine state for one tick
    always_comb
    begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        tick_next      = tick_reg;
        rx_next        = rx_reg;
        nack_next      = nack_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        done_next      = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            // Take a command, counting starts on the next tick
            tick_next = 8'd0;
            case (kind)
                KIND_START:
                begin
                    phase_next = PH_ST_A;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end
                KIND_STOP:
                begin
                    phase_next = PH_SP_A;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                end
                KIND_WRITE:
                begin
                    phase_next     = PH_WR_LO;
                    shift_next     = tx_byte;
                    bit_count_next = 4'd0;
                    scl_next       = 1'b0;
                    sda_next       = tx_byte[7];
                end
                KIND_READ_ACK, KIND_READ_NAK:
                begin
                    phase_next     = PH_RD_LO;
                    shift_next     = 8'd0;
                    bit_count_next = (kind == KIND_READ_NAK) ? BITS_PER_BYTE : 4'd0;
                    scl_next       = 1'b0;
                    sda_next       = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        else if (tick_inc < {1'b0, delay_eff})
        begin
            // Still inside the current phase
            tick_next = tick_inc[7:0];
        end
        else
        begin
            // Phase ends: sample and advance
            tick_next = 8'd0;
            case (phase_reg)
                PH_ST_A:
                begin
                    phase_next = PH_ST_B;
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                end
                PH_ST_B:
                begin
                    phase_next = PH_HOLD;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                end
                PH_SP_A:
                begin
                    phase_next = PH_SP_B;
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                end
                PH_SP_B:
                begin
                    phase_next = PH_SP_C;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end
                PH_WR_LO:
                begin
                    phase_next = PH_WR_HI;
                    scl_next   = 1'b1;
                    sda_next   = shift_reg[7];
                end
                PH_WR_HI:
                begin
                    shift_next     = shift_wr;
                    bit_count_next = bit_inc;
                    scl_next       = 1'b0;
                    if (bit_inc >= BITS_PER_BYTE)
                    begin
                        phase_next = PH_WA_LO;
                        sda_next   = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_WR_LO;
                        sda_next   = shift_wr[7];
                    end
                end
                PH_WA_LO:
                begin
                    phase_next = PH_WA_HI;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end
                PH_WA_HI:
                begin
                    nack_next  = sda_in;
                    phase_next = PH_HOLD;
                    scl_next   = 1'b0;
                    sda_next   = 1'b1;
                end
                PH_RD_LO:
                begin
                    phase_next = PH_RD_HI;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end
                PH_RD_HI:
                begin
                    shift_next = shift_rd;
                    scl_next   = 1'b0;
                    if (bit_count_reg[2:0] == 3'd7)
                    begin
                        bit_count_next = {ack_level, 3'd0};
                        rx_next        = shift_rd;
                        phase_next     = PH_RA_LO;
                        sda_next       = ack_level;
                    end
                    else
                    begin
                        bit_count_next = {ack_level, bit_inc[2:0]};
                        phase_next     = PH_RD_LO;
                        sda_next       = 1'b1;
                    end
                end
                PH_RA_LO:
                begin
                    phase_next = PH_RA_HI;
                    scl_next   = 1'b1;
                    sda_next   = ack_level;
                end
                PH_RA_HI:
                begin
                    phase_next = PH_HOLD;
                    scl_next   = 1'b0;
                    sda_next   = ack_level;
                end
                PH_HOLD:
                begin
                    phase_next = PH_IDLE;
                    scl_next   = 1'b0;
                    sda_next   = 1'b1;
                    done_next  = 1'b1;
                end
                default:
                begin
                    // Stop end, or an unused code: release the bus
                    phase_next = PH_IDLE;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    done_next  = 1'b1;
                end
            endcase
        end
    end

    // Form the result word of this tick
    always_comb
    begin
        result_next.scl_out  = scl_next;
        result_next.sda_out  = sda_next;
        result_next.busy_res = (phase_next != PH_IDLE);
        result_next.done_res = done_next;
        result_next.rx_byte  = rx_next;
        result_next.nack     = nack_next;
        result_next.bus_idle = sda_in & scl_in;
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
        end
        else if (cfg_wr_en)
        begin
            delay_reg <= cfg_wr_data;
        end
    end

    // Engine state registers, advance once per accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_count_reg <= 4'd0;
            shift_reg     <= 8'd0;
            tick_reg      <= 8'd0;
            rx_reg        <= 8'd0;
            nack_reg      <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            tick_reg      <= tick_next;
            rx_reg        <= rx_next;
            nack_reg      <= nack_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
        end
    end

    // Output register with skid: drain skid first, else load the new word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (accept)
            begin
                out_data_reg <= result_next;
            end
        end
        else if (accept)
        begin
            skid_data_reg <= result_next;
        end
    end

    // Drive ports
    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign scl_out   = out_data_reg.scl_out;
    assign sda_out   = out_data_reg.sda_out;
    assign busy_res  = out_data_reg.busy_res;
    assign done_res  = out_data_reg.done_res;
    assign rx_byte   = out_data_reg.rx_byte;
    assign nack      = out_data_reg.nack;
    assign bus_idle  = out_data_reg.bus_idle;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for i2c_master_byte_engine_unit: directed table, then random ticks.
// Depends on i2cmbe_pkg and the engine RTL; predicts result words in-line, typed table rows apart.
module tb;
    import i2cmbe_pkg::*;

    // Command codes the engine must ignore like KIND_NONE
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;
    localparam logic [7:0] DELAY_ZERO   = 8'd0;
    localparam logic [7:0] DELAY_LONG   = 8'd128;
    localparam int         QUIET_LIMIT  = 4000;
    localparam int         FAST_ROW     = 7;

    typedef struct packed {
        logic [2:0] k;
        logic [7:0] tx;
        logic       sda;
        logic       scl;
        logic       settle;
        logic       hold;
        logic       typed;
        result_t    want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] kind = KIND_NONE;
    logic [7:0] tx_byte = 8'd0;
    logic       sda_in = 1'b1;
    logic       scl_in = 1'b1;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack;
    logic       bus_idle;

    // Engine state as predicted by the bench
    phase_t     eng_phase;
    logic [3:0] eng_bits;
    logic [7:0] eng_shift;
    logic [7:0] eng_ticks;
    logic [7:0] eng_rx;
    logic       eng_nack;
    logic [1:0] eng_lines;
    logic [7:0] eng_delay;

    result_t    bus_results_due[$];
    int         mismatches = 0;
    int         quiet_cycles = 0;
    bit         steady = 1'b0;
    stim_row_t  dir_rows [0:15];

    i2c_master_byte_engine_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .tx_byte    (tx_byte),
        .sda_in     (sda_in),
        .scl_in     (scl_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .scl_out    (scl_out),
        .sda_out    (sda_out),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .rx_byte    (rx_byte),
        .nack       (nack),
        .bus_idle   (bus_idle)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Load the next bus phase and the line levels it holds
    function automatic void move_to(phase_t nxt, logic c, logic s);
        eng_phase = nxt;
        eng_lines = {c, s};
    endfunction

    // Advance the engine by one tick and form the result word it shows
    task automatic engine_tick(input logic [2:0] k, input logic [7:0] tx, input logic sda,
                               input logic scl, output result_t r);
        logic [7:0] d;
        logic       fin;
        logic       ackl;
        d = (eng_delay == DELAY_ZERO) ? DELAY_MIN : eng_delay;
        fin = 1'b0;
        ackl = eng_bits[ACK_BIT];
        if (eng_phase == PH_IDLE)
        begin
            eng_ticks = 8'd0;
            case (k)
                KIND_START: move_to(PH_ST_A, 1'b1, 1'b1);
                KIND_STOP:  move_to(PH_SP_A, 1'b0, 1'b0);
                KIND_WRITE:
                begin
                    eng_shift = tx;
                    eng_bits = 4'd0;
                    move_to(PH_WR_LO, 1'b0, tx[7]);
                end
                KIND_READ_ACK, KIND_READ_NAK:
                begin
                    eng_shift = 8'd0;
                    eng_bits = (k == KIND_READ_NAK) ? BITS_PER_BYTE : 4'd0;
                    move_to(PH_RD_LO, 1'b0, 1'b1);
                end
                default: ;
            endcase
        end
        else
        begin
            eng_ticks = eng_ticks + 8'd1;
            if (eng_ticks >= d)
            begin
                eng_ticks = 8'd0;
                case (eng_phase)
                    PH_ST_A:  move_to(PH_ST_B, 1'b1, 1'b0);
                    PH_ST_B:  move_to(PH_HOLD, 1'b0, 1'b0);
                    PH_SP_A:  move_to(PH_SP_B, 1'b1, 1'b0);
                    PH_SP_B:  move_to(PH_SP_C, 1'b1, 1'b1);
                    PH_SP_C:
                    begin
                        move_to(PH_IDLE, 1'b1, 1'b1);
                        fin = 1'b1;
                    end
                    PH_WR_LO: move_to(PH_WR_HI, 1'b1, eng_shift[7]);
                    PH_WR_HI:
                    begin
                        eng_shift = eng_shift << 1;
                        eng_bits = eng_bits + 4'd1;
                        if (eng_bits >= BITS_PER_BYTE)
                            move_to(PH_WA_LO, 1'b0, 1'b1);
                        else
                            move_to(PH_WR_LO, 1'b0, eng_shift[7]);
                    end
                    PH_WA_LO: move_to(PH_WA_HI, 1'b1, 1'b1);
                    PH_WA_HI:
                    begin
                        eng_nack = sda;
                        move_to(PH_HOLD, 1'b0, 1'b1);
                    end
                    PH_RD_LO: move_to(PH_RD_HI, 1'b1, 1'b1);
                    PH_RD_HI:
                    begin
                        eng_shift = {eng_shift[6:0], sda};
                        if (eng_bits[2:0] == 3'd7)
                        begin
                            eng_bits = {ackl, 3'd0};
                            eng_rx = eng_shift;
                            move_to(PH_RA_LO, 1'b0, ackl);
                        end
                        else
                        begin
                            eng_bits = {ackl, eng_bits[2:0] + 3'd1};
                            move_to(PH_RD_LO, 1'b0, 1'b1);
                        end
                    end
                    PH_RA_LO: move_to(PH_RA_HI, 1'b1, ackl);
                    PH_RA_HI: move_to(PH_HOLD, 1'b0, ackl);
                    PH_HOLD:
                    begin
                        move_to(PH_IDLE, 1'b0, 1'b1);
                        fin = 1'b1;
                    end
                    default:
                    begin
                        move_to(PH_IDLE, 1'b1, 1'b1);
                        fin = 1'b1;
                    end
                endcase
            end
        end
        r.scl_out  = eng_lines[1];
        r.sda_out  = eng_lines[0];
        r.busy_res = (eng_phase != PH_IDLE);
        r.done_res = fin;
        r.rx_byte  = eng_rx;
        r.nack     = eng_nack;
        r.bus_idle = sda & scl;
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Drive one word, hold it until accepted, then queue its expected result
    task automatic send_tick(input logic [2:0] k, input logic [7:0] tx, input logic sda,
                             input logic scl, input bit use_want, input result_t want);
        result_t predicted;
        @(negedge clk);
        while (!steady && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        tx_byte  <= tx;
        sda_in   <= sda;
        scl_in   <= scl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        engine_tick(k, tx, sda, scl, predicted);
        bus_results_due.push_back(use_want ? want : predicted);
    endtask

    // Tick the engine until its command ends; stray commands in between must be dropped
    task automatic finish_command(input bit hold, input logic sda_level);
        logic [2:0] k;
        while (eng_phase != PH_IDLE)
        begin
            k = ($urandom_range(99) < 85) ? KIND_NONE
                                          : 3'($urandom_range(KIND_SPARE_B, KIND_NONE));
            send_tick(k, 8'($urandom), hold ? sda_level : 1'($urandom), 1'($urandom),
                      1'b0, '0);
        end
    endtask

    // Drop valid and wait for every queued result word
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (bus_results_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_delay(input logic [7:0] v);
        finish_command(1'b0, 1'b0);
        quiesce();
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        eng_delay = v;
    endtask

    // Random ticks: usually a fresh command when idle, mostly plain ticks while busy
    task automatic run_random(input int n);
        logic [2:0] k;
        repeat (n)
        begin
            if (eng_phase == PH_IDLE)
            begin
                if ($urandom_range(99) < 90)
                    k = 3'($urandom_range(KIND_READ_NAK, KIND_START));
                else if ($urandom_range(1) != 0)
                    k = KIND_NONE;
                else
                    k = 3'($urandom_range(KIND_SPARE_B, KIND_SPARE_A));
            end
            else
                k = ($urandom_range(99) < 85) ? KIND_NONE
                                              : 3'($urandom_range(KIND_SPARE_B, KIND_NONE));
            send_tick(k, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
        end
    endtask

    // Result side back-pressure
    always @(negedge clk)
        out_stall <= steady ? 1'b0 : ($urandom_range(99) < 26);

    // Compare each delivered word with the oldest expectation
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{scl_out, sda_out, busy_res, done_res, rx_byte, nack, bus_idle};
            if (bus_results_due.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                want = bus_results_due.pop_front();
                check_field("scl_out", 8'(got.scl_out), 8'(want.scl_out));
                check_field("sda_out", 8'(got.sda_out), 8'(want.sda_out));
                check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
                check_field("done_res", 8'(got.done_res), 8'(want.done_res));
                check_field("rx_byte", got.rx_byte, want.rx_byte);
                check_field("nack", 8'(got.nack), 8'(want.nack));
                check_field("bus_idle", 8'(got.bus_idle), 8'(want.bus_idle));
            end
        end
    end

    // Count cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        stim_row_t row;
        // idle ticks, spare codes and START at the reset delay; the rest run at delay 1
        dir_rows = '{
            '{KIND_NONE,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
              '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}},
            '{KIND_NONE,     8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
              '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}},
            '{KIND_NONE,     8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
              '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}},
            '{KIND_NONE,     8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
              '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1}},
            '{KIND_SPARE_A,  8'h55, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
              '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1}},
            '{KIND_SPARE_B,  8'hAA, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
              '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}},
            '{KIND_START,    8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
              '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1}},
            '{KIND_WRITE,    8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
              '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}},
            '{KIND_WRITE,    8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
              '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1}},
            '{KIND_READ_ACK, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, '0},
            '{KIND_READ_NAK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, '0},
            '{KIND_READ_ACK, 8'hA5, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, '0},
            '{KIND_STOP,     8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0},
            '{KIND_WRITE,    8'h5A, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, '0},
            '{KIND_START,    8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '0},
            '{KIND_STOP,     8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, '0}
        };

        eng_phase = PH_IDLE;
        eng_bits  = 4'd0;
        eng_shift = 8'd0;
        eng_ticks = 8'd0;
        eng_rx    = 8'd0;
        eng_nack  = 1'b0;
        eng_lines = 2'b11;
        eng_delay = DELAY_RESET;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        for (int i = 0; i < $size(dir_rows); i++)
        begin
            row = dir_rows[i];
            if (i == FAST_ROW)
                set_delay(DELAY_MIN);
            send_tick(row.k, row.tx, row.sda, row.scl, row.typed, row.want);
            if (row.settle)
                finish_command(row.hold, row.sda);
        end

        // Random part over several phase lengths
        run_random(180);
        set_delay(DELAY_ZERO);
        run_random(80);
        quiesce();
        run_random(30);
        set_delay(8'd2);
        steady = 1'b1;
        run_random(200);
        finish_command(1'b0, 1'b0);
        steady = 1'b0;
        // Long phases: one start or stop keeps the tick count bounded
        set_delay(DELAY_LONG);
        send_tick(($urandom_range(1) != 0) ? KIND_START : KIND_STOP, 8'($urandom),
                  1'($urandom), 1'($urandom), 1'b0, '0);
        finish_command(1'b0, 1'b0);
        set_delay(8'd3);
        run_random(90);
        set_delay(8'd7);
        run_random(70);
        set_delay(DELAY_MIN);
        run_random(50);

        // Drain and settle
        finish_command(1'b0, 1'b0);
        quiesce();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
